### hw/rtl/psp_pkg.sv
package psp_pkg;

	// Pool geometry. The free-slot search splits the flags into groups of GRP_W.
	localparam int POOL_DEPTH = 256;
	localparam int SLOT_W     = $clog2(POOL_DEPTH);
	localparam int CNT_W      = SLOT_W + 1;
	localparam int GRP_W      = 16;
	localparam int NUM_GRP    = POOL_DEPTH / GRP_W;
	localparam int GRP_IDX_W  = $clog2(NUM_GRP);
	localparam int LANE_W     = $clog2(GRP_W);

	// Result status codes.
	typedef enum logic [1:0] {
		ST_ALLOC   = 2'd0,
		ST_REUSE   = 2'd1,
		ST_RELEASE = 2'd2,
		ST_BAD_POS = 2'd3
	} status_t;

	// Controller states.
	typedef enum logic [2:0] {
		S_IDLE,
		S_GRP,
		S_ALLOC,
		S_REUSE,
		S_BAD,
		S_REL_A,
		S_REL_B,
		S_REL_C
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic    load_in;
		logic    grp_en;
		logic    rd_last;
		logic    cap_slot;
		logic    commit;
		status_t commit_op;
	} ctl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic rel_req;
		logic bad_pos;
		logic full;
		logic out_free;
	} dp_stat_t;

endpackage

### hw/rtl/psp_ctrl.sv
module psp_ctrl
	import psp_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  dp_stat_t  stat,
	output ctl_cmd_t  cmd
);

	state_t state_q;
	state_t state_nxt;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Next-state logic.
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					if (stat.rel_req) begin
						state_nxt = stat.bad_pos ? S_BAD : S_REL_A;
					end else begin
						state_nxt = stat.full ? S_REUSE : S_GRP;
					end
				end
			end
			S_GRP:   state_nxt = S_ALLOC;
			S_REL_A: state_nxt = S_REL_B;
			S_REL_B: state_nxt = S_REL_C;
			S_ALLOC, S_REUSE, S_BAD, S_REL_C: begin
				if (stat.out_free) begin
					state_nxt = S_IDLE;
				end
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	// Output logic.
	always_comb begin
		in_ready      = 1'b0;
		cmd           = '0;
		cmd.commit_op = ST_ALLOC;
		case (state_q)
			S_IDLE: begin
				in_ready    = 1'b1;
				cmd.load_in = in_valid;
			end
			S_GRP: begin
				cmd.grp_en = 1'b1;
			end
			S_ALLOC: begin
				cmd.commit    = stat.out_free;
				cmd.commit_op = ST_ALLOC;
			end
			S_REUSE: begin
				cmd.commit    = stat.out_free;
				cmd.commit_op = ST_REUSE;
			end
			S_BAD: begin
				cmd.commit    = stat.out_free;
				cmd.commit_op = ST_BAD_POS;
			end
			S_REL_A: begin
				cmd.rd_last = 1'b0;
			end
			S_REL_B: begin
				cmd.cap_slot = 1'b1;
				cmd.rd_last  = 1'b1;
			end
			S_REL_C: begin
				cmd.rd_last   = 1'b1;
				cmd.commit    = stat.out_free;
				cmd.commit_op = ST_RELEASE;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

endmodule

### hw/rtl/psp_dp.sv
module psp_dp
	import psp_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [CNT_W-1:0]  cfg_wdata,
	input  logic              mode,
	input  logic [SLOT_W-1:0] list_position,
	input  ctl_cmd_t          cmd,
	output dp_stat_t          stat,
	input  logic              out_ready,
	output logic              out_valid,
	output logic [1:0]        status,
	output logic [SLOT_W-1:0] slot,
	output logic [SLOT_W-1:0] position,
	output logic [CNT_W-1:0]  active_count,
	output logic [CNT_W-1:0]  high_water
);

	// Lowest set bit of the group summary.
	function automatic logic [GRP_IDX_W-1:0] first_grp(input logic [NUM_GRP-1:0] v);
		logic [GRP_IDX_W-1:0] r;
		r = '0;
		for (int i = NUM_GRP - 1; i >= 0; i--) begin
			if (v[i]) r = GRP_IDX_W'(i);
		end
		return r;
	endfunction

	// Lowest set bit within one group.
	function automatic logic [LANE_W-1:0] first_lane(input logic [GRP_W-1:0] v);
		logic [LANE_W-1:0] r;
		r = '0;
		for (int i = GRP_W - 1; i >= 0; i--) begin
			if (v[i]) r = LANE_W'(i);
		end
		return r;
	endfunction

	// Pool state.
	logic [CNT_W-1:0]      size_q;
	logic [POOL_DEPTH-1:0] flags_q;
	logic [CNT_W-1:0]      count_q;
	logic [SLOT_W-1:0]     search_q;
	logic [SLOT_W-1:0]     reuse_q;
	logic [CNT_W-1:0]      peak_q;

	// Active list memory and its registered read data.
	logic [SLOT_W-1:0] list_mem [POOL_DEPTH];
	logic [SLOT_W-1:0] rd_q;
	logic [SLOT_W-1:0] mem_raddr;
	logic              mem_we;
	logic [SLOT_W-1:0] mem_waddr;
	logic [SLOT_W-1:0] mem_wdata;

	// Transaction and search registers.
	logic [SLOT_W-1:0]    lpos_q;
	logic [SLOT_W-1:0]    rel_slot_q;
	logic [GRP_IDX_W-1:0] grp_s1;
	logic                 sel_hi_s1;
	logic                 none_s1;

	// Output register.
	logic              out_valid_q;
	status_t           status_q;
	logic [SLOT_W-1:0] slot_q;
	logic [SLOT_W-1:0] pos_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [CNT_W-1:0]  hw_q;

	// Search masks.
	logic [POOL_DEPTH-1:0]           in_range;
	logic [POOL_DEPTH-1:0]           at_or_after;
	logic [POOL_DEPTH-1:0]           free_flat;
	logic [POOL_DEPTH-1:0]           hi_flat;
	logic [NUM_GRP-1:0][GRP_W-1:0]   free_g;
	logic [NUM_GRP-1:0][GRP_W-1:0]   hi_g;
	logic [NUM_GRP-1:0]              any_free;
	logic [NUM_GRP-1:0]              any_hi;
	logic [GRP_W-1:0]                lane_v;
	logic [SLOT_W-1:0]               cand;
	logic [CNT_W-1:0]                cand_inc;
	logic [SLOT_W-1:0]               search_nxt;
	logic [CNT_W-1:0]                size_m1;
	logic [CNT_W-1:0]                reuse_inc;
	logic [SLOT_W-1:0]               reuse_nxt;
	logic [CNT_W-1:0]                count_inc;
	logic [CNT_W-1:0]                count_dec;
	logic [CNT_W-1:0]                peak_nxt;
	logic [CNT_W-1:0]                size_eff;

	// Slots that are free and inside the pool, and those at or after the search pointer.
	always_comb begin
		for (int i = 0; i < POOL_DEPTH; i++) begin
			in_range[i]    = CNT_W'(i) < size_q;
			at_or_after[i] = SLOT_W'(i) >= search_q;
		end
	end

	assign free_flat = ~flags_q & in_range;
	assign hi_flat   = free_flat & at_or_after;
	assign free_g    = free_flat;
	assign hi_g      = hi_flat;

	// Group summaries for the first search stage.
	always_comb begin
		for (int g = 0; g < NUM_GRP; g++) begin
			any_free[g] = |free_g[g];
			any_hi[g]   = |hi_g[g];
		end
	end

	// Second search stage: pick the lane inside the chosen group.
	assign lane_v   = sel_hi_s1 ? hi_g[grp_s1] : free_g[grp_s1];
	assign size_m1  = size_q - CNT_W'(1);

	always_comb begin
		if (none_s1) begin
			cand = (search_q == '0) ? size_m1[SLOT_W-1:0] : search_q - SLOT_W'(1);
		end else begin
			cand = {grp_s1, first_lane(lane_v)};
		end
	end

	assign cand_inc   = {1'b0, cand} + CNT_W'(1);
	assign search_nxt = none_s1 ? search_q :
	                    ((cand_inc == size_q) ? '0 : cand_inc[SLOT_W-1:0]);

	// Pointer and counter arithmetic.
	assign reuse_inc = {1'b0, reuse_q} + CNT_W'(1);
	assign reuse_nxt = (reuse_inc == size_q) ? '0 : reuse_inc[SLOT_W-1:0];
	assign count_inc = count_q + CNT_W'(1);
	assign count_dec = count_q - CNT_W'(1);
	assign peak_nxt  = (count_inc > peak_q) ? count_inc : peak_q;

	// Effective size for a configuration write.
	always_comb begin
		if (cfg_wdata == '0) begin
			size_eff = CNT_W'(1);
		end else if (cfg_wdata > CNT_W'(POOL_DEPTH)) begin
			size_eff = CNT_W'(POOL_DEPTH);
		end else begin
			size_eff = cfg_wdata;
		end
	end

	// Status toward the controller.
	assign stat.rel_req  = mode;
	assign stat.bad_pos  = {1'b0, list_position} >= count_q;
	assign stat.full     = count_q >= size_q;
	assign stat.out_free = !out_valid_q || out_ready;

	// Pool state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q   <= CNT_W'(POOL_DEPTH);
			flags_q  <= '0;
			count_q  <= '0;
			search_q <= '0;
			reuse_q  <= '0;
			peak_q   <= '0;
		end else if (cfg_we) begin
			size_q   <= size_eff;
			flags_q  <= '0;
			count_q  <= '0;
			search_q <= '0;
			reuse_q  <= '0;
			peak_q   <= '0;
		end else if (cmd.commit) begin
			case (cmd.commit_op)
				ST_ALLOC: begin
					flags_q[cand] <= 1'b1;
					search_q      <= search_nxt;
					count_q       <= count_inc;
					peak_q        <= peak_nxt;
				end
				ST_REUSE: begin
					flags_q[reuse_q] <= 1'b1;
					reuse_q          <= reuse_nxt;
				end
				ST_RELEASE: begin
					flags_q[rel_slot_q] <= 1'b0;
					search_q            <= rel_slot_q;
					count_q             <= count_dec;
				end
				default: begin
					count_q <= count_q;
				end
			endcase
		end
	end

	// Output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Captured request, the first search stage and the captured release slot.
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			lpos_q <= list_position;
		end
		if (cmd.grp_en) begin
			sel_hi_s1 <= |any_hi;
			none_s1   <= ~(|any_free);
			grp_s1    <= (|any_hi) ? first_grp(any_hi) : first_grp(any_free);
		end
		if (cmd.cap_slot) begin
			rel_slot_q <= rd_q;
		end
	end

	// Active list accesses: append on allocate, fill the gap on release.
	assign mem_raddr = cmd.rd_last ? count_dec[SLOT_W-1:0] : lpos_q;
	assign mem_we    = cmd.commit &&
	                   (cmd.commit_op == ST_ALLOC || cmd.commit_op == ST_RELEASE);
	assign mem_waddr = (cmd.commit_op == ST_ALLOC) ? count_q[SLOT_W-1:0] : lpos_q;
	assign mem_wdata = (cmd.commit_op == ST_ALLOC) ? cand : rd_q;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			list_mem[mem_waddr] <= mem_wdata;
		end
		rd_q <= list_mem[mem_raddr];
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			status_q <= cmd.commit_op;
			case (cmd.commit_op)
				ST_ALLOC: begin
					slot_q <= cand;
					pos_q  <= count_q[SLOT_W-1:0];
					cnt_q  <= count_inc;
					hw_q   <= peak_nxt;
				end
				ST_REUSE: begin
					slot_q <= reuse_q;
					pos_q  <= reuse_q;
					cnt_q  <= count_q;
					hw_q   <= peak_q;
				end
				ST_RELEASE: begin
					slot_q <= rel_slot_q;
					pos_q  <= lpos_q;
					cnt_q  <= count_dec;
					hw_q   <= peak_q;
				end
				default: begin
					slot_q <= '0;
					pos_q  <= lpos_q;
					cnt_q  <= count_q;
					hw_q   <= peak_q;
				end
			endcase
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign slot         = slot_q;
	assign position     = pos_q;
	assign active_count = cnt_q;
	assign high_water   = hw_q;

endmodule

### hw/rtl/particle_slot_pool_allocator_top.sv
// Channel   Handshake            Payload
// input     in_valid / in_ready  mode, list_position
// output    out_valid / out_ready status, slot, position, active_count, high_water
// config    cfg_we               cfg_wdata (pool size, write clears the pool)
//
// One transaction at a time. A reuse or a bad release position goes straight to its result step,
// an allocation from the free slots first runs a two-stage search over groups of flags,
// and a release does two reads of the active list, then the write.
// Reset clears all flags, counters and pointers at once and sets the size to the full depth.
// A full output register holds the finishing step until the result is taken.
module particle_slot_pool_allocator_top
	import psp_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [CNT_W-1:0]  cfg_wdata,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              mode,
	input  logic [SLOT_W-1:0] list_position,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [1:0]        status,
	output logic [SLOT_W-1:0] slot,
	output logic [SLOT_W-1:0] position,
	output logic [CNT_W-1:0]  active_count,
	output logic [CNT_W-1:0]  high_water
);

	ctl_cmd_t dp_cmd;
	dp_stat_t dp_stat;

	// Sequencer.
	psp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (dp_stat),
		.cmd      (dp_cmd)
	);

	// Flags, active list, pointers and the output register.
	psp_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.mode          (mode),
		.list_position (list_position),
		.cmd           (dp_cmd),
		.stat          (dp_stat),
		.out_ready     (out_ready),
		.out_valid     (out_valid),
		.status        (status),
		.slot          (slot),
		.position      (position),
		.active_count  (active_count),
		.high_water    (high_water)
	);

`ifndef SYNTHESIS
	// A result is only written into a free output register.
	a_commit_free: assert property (@(posedge clk) disable iff (!arst_n)
		dp_cmd.commit |-> (!out_valid || out_ready))
		else $error("result committed over an untaken result");

	// The active count shown never exceeds the high water mark.
	a_count_le_peak: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (active_count <= high_water))
		else $error("active count above high water mark");

	// An accepted transaction blocks the input for at least the next cycle.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("input accepted while a transaction is in progress");
`endif

endmodule
